// ===== hdl/rpd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Radio packet deframer package
// Shared constants, result codes and the command word passed from the
// classifier to the time-stamping back end.
// ----------------------------------------------------------------------------
package rpd_pkg;

  localparam int MAX_LEN       = 128;
  localparam int LEN_POS       = 12;
  localparam int PAYLOAD_START = 14;
  localparam int BACKLOG_MAX   = 64;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [2:0] ST_IGNORE   = 3'd0;
  localparam logic [2:0] ST_BYTE     = 3'd1;
  localparam logic [2:0] ST_DONE     = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_BAD_LEN  = 3'd4;
  localparam logic [2:0] ST_TOO_LONG = 3'd5;

  localparam logic [1:0] REG_PREAMBLE = 2'd0;
  localparam logic [1:0] REG_BYTE     = 2'd1;
  localparam logic [1:0] REG_GUARD    = 2'd2;

  typedef struct packed {
    logic [2:0]        status;
    logic              sync_take;
    logic [7:0]        byte_out;
    logic [7:0]        byte_index;
    logic [7:0]        packet_length;
    logic signed [7:0] rssi;
    logic [31:0]       now_us;
    logic [6:0]        backlog;
  } cmd_t;

endpackage
`default_nettype wire

// ===== hdl/rpd_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Radio packet deframer channels
// Input item channel and result channel, each with valid, ready and payload.
// ----------------------------------------------------------------------------
interface rpd_in_if;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [7:0]        rx_byte;
  logic [31:0]       now_us;
  logic [6:0]        backlog_bytes;
  logic              fifo_overflow;
  logic signed [7:0] signal_strength;

  modport source (output valid, req_type, rx_byte, now_us, backlog_bytes,
                  fifo_overflow, signal_strength, input ready);
  modport sink   (input valid, req_type, rx_byte, now_us, backlog_bytes,
                  fifo_overflow, signal_strength, output ready);
endinterface

interface rpd_out_if;
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [7:0]        byte_out;
  logic [7:0]        byte_index;
  logic [7:0]        packet_length;
  logic [31:0]       start_time_us;
  logic [31:0]       end_time_us;
  logic signed [7:0] rssi_out;

  modport source (output valid, status, byte_out, byte_index, packet_length,
                  start_time_us, end_time_us, rssi_out, input ready);
  modport sink   (input valid, status, byte_out, byte_index, packet_length,
                  start_time_us, end_time_us, rssi_out, output ready);
endinterface
`default_nettype wire

// ===== hdl/rpd_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Radio packet deframer front end
// Tracks the framing state, classifies each item and issues a command word.
// ----------------------------------------------------------------------------
module rpd_front
  import rpd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  rpd_in_if.sink    item,
  output logic      push_valid,
  output cmd_t      push_data,
  input  wire logic push_ready
);

  localparam logic [1:0] PH_WAIT    = 2'd0;
  localparam logic [1:0] PH_HEADER  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;
  localparam logic [8:0] LEN_UNKNOWN = 9'h1FF;

  logic [1:0] phase, phase_next;
  logic [7:0] bytes_received, bytes_received_next;
  logic [8:0] expected_length, expected_length_next;
  logic [7:0] first_length_copy, first_length_copy_next;

  logic       accept;
  logic [8:0] br_inc;
  logic [7:0] flc_new;
  logic [8:0] exp_eff;
  logic       len_ok;
  cmd_t       cmd;

  assign item.ready = push_ready;
  assign accept     = item.valid && push_ready;
  assign push_valid = item.valid;
  assign push_data  = cmd;

  always_comb begin
    phase_next             = phase;
    bytes_received_next    = bytes_received;
    expected_length_next   = expected_length;
    first_length_copy_next = first_length_copy;
    cmd                    = '0;
    cmd.status             = ST_IGNORE;
    cmd.now_us             = item.now_us;
    cmd.backlog            = item.backlog_bytes;
    br_inc  = {1'b0, bytes_received} + 9'd1;
    flc_new = (bytes_received == 8'(LEN_POS)) ? item.rx_byte : first_length_copy;
    exp_eff = expected_length;
    len_ok  = (flc_new == item.rx_byte) && (flc_new < 8'(MAX_LEN - 3)) &&
              (({1'b0, flc_new} + 9'd2) >= 9'(PAYLOAD_START));
    if (!item.req_type) begin
      if (phase == PH_WAIT) begin
        phase_next             = PH_WAIT;
        bytes_received_next    = '0;
        expected_length_next   = LEN_UNKNOWN;
        first_length_copy_next = '0;
        if (item.fifo_overflow || (item.backlog_bytes > 7'(BACKLOG_MAX))) begin
          cmd.status = ST_OVERFLOW;
        end else begin
          phase_next    = PH_HEADER;
          cmd.sync_take = 1'b1;
        end
      end
    end else if (phase != PH_WAIT) begin
      if (item.fifo_overflow || (br_inc > 9'(MAX_LEN))) begin
        cmd.status             = item.fifo_overflow ? ST_OVERFLOW : ST_TOO_LONG;
        phase_next             = PH_WAIT;
        bytes_received_next    = '0;
        expected_length_next   = LEN_UNKNOWN;
        first_length_copy_next = '0;
      end else begin
        cmd.status             = ST_BYTE;
        cmd.byte_out           = item.rx_byte;
        cmd.byte_index         = bytes_received;
        bytes_received_next    = br_inc[7:0];
        first_length_copy_next = flc_new;
        if ((phase == PH_HEADER) && ({1'b0, br_inc[7:0]} >= 9'(LEN_POS + 2))) begin
          phase_next = PH_PAYLOAD;
          if (len_ok) begin
            exp_eff              = {1'b0, flc_new} + 9'd2;
            expected_length_next = exp_eff;
          end else begin
            cmd                    = '0;
            cmd.status             = ST_BAD_LEN;
            phase_next             = PH_WAIT;
            bytes_received_next    = '0;
            expected_length_next   = LEN_UNKNOWN;
            first_length_copy_next = '0;
          end
        end
        if ((cmd.status == ST_BYTE) && (exp_eff != LEN_UNKNOWN) &&
            ({1'b0, br_inc[7:0]} >= exp_eff)) begin
          cmd.status             = ST_DONE;
          cmd.packet_length      = exp_eff[7:0];
          cmd.rssi               = item.signal_strength;
          phase_next             = PH_WAIT;
          bytes_received_next    = '0;
          expected_length_next   = LEN_UNKNOWN;
          first_length_copy_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_WAIT;
      bytes_received    <= '0;
      expected_length   <= LEN_UNKNOWN;
      first_length_copy <= '0;
    end else if (accept) begin
      phase             <= phase_next;
      bytes_received    <= bytes_received_next;
      expected_length   <= expected_length_next;
      first_length_copy <= first_length_copy_next;
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd.status == ST_DONE) |=> (phase == PH_WAIT))
    else $error("front not idle after packet completion");

  a_len_phase: assert property (@(posedge clk) disable iff (rst)
    (expected_length != LEN_UNKNOWN) |-> (phase == PH_PAYLOAD))
    else $error("length known outside payload phase");

endmodule
`default_nettype wire

// ===== hdl/rpd_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Radio packet deframer command queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module rpd_queue
  import rpd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  input  wire cmd_t push_data,
  output logic      push_ready,
  output logic      pop_valid,
  output cmd_t      pop_data,
  input  wire logic pop
);

  cmd_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QCNT_W'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");

endmodule
`default_nettype wire

// ===== hdl/rpd_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Radio packet deframer back end
// Holds the timing registers, multiplies byte counts by the byte time and
// forms the start time stamp on sync and both time stamps on completion.
// ----------------------------------------------------------------------------
module rpd_back
  import rpd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        q_valid,
  input  wire cmd_t        q_data,
  output logic             q_pop,
  rpd_out_if.source        result
);

  logic [15:0] preamble_time_us;
  logic [15:0] byte_time_us;
  logic [15:0] guard_time_us;

  logic        a_valid;
  cmd_t        a_cmd;
  logic [23:0] a_prod;
  logic        adv_a;
  logic        adv_b;
  logic [7:0]  mul_op;

  logic [31:0] packet_start_time;
  logic [31:0] start_calc;
  logic [31:0] end_calc;

  logic              out_valid;
  logic [2:0]        out_status;
  logic [7:0]        out_byte;
  logic [7:0]        out_index;
  logic [7:0]        out_length;
  logic [31:0]       out_start;
  logic [31:0]       out_end;
  logic signed [7:0] out_rssi;

  always_ff @(posedge clk) begin
    if (rst) begin
      preamble_time_us <= '0;
      byte_time_us     <= '0;
      guard_time_us    <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PREAMBLE: preamble_time_us <= cfg_data;
        REG_BYTE:     byte_time_us     <= cfg_data;
        REG_GUARD:    guard_time_us    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign adv_b  = !out_valid || result.ready;
  assign adv_a  = !a_valid || adv_b;
  assign q_pop  = q_valid && adv_a;
  assign mul_op = q_data.sync_take ? {1'b0, q_data.backlog} : q_data.packet_length;

  always_ff @(posedge clk) begin
    if (adv_a) begin
      a_cmd  <= q_data;
      a_prod <= 24'(mul_op) * 24'(byte_time_us);
    end
  end

  assign start_calc = a_cmd.now_us - 32'(preamble_time_us) - 32'(a_prod);
  assign end_calc   = packet_start_time + 32'(preamble_time_us) + 32'(a_prod) +
                      32'(guard_time_us);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid           <= 1'b0;
      out_valid         <= 1'b0;
      packet_start_time <= '0;
    end else begin
      if (adv_a) begin
        a_valid <= q_valid;
      end
      if (adv_b) begin
        out_valid <= a_valid;
        if (a_valid && a_cmd.sync_take) begin
          packet_start_time <= start_calc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_b) begin
      out_status <= a_cmd.status;
      out_byte   <= a_cmd.byte_out;
      out_index  <= a_cmd.byte_index;
      out_length <= a_cmd.packet_length;
      out_rssi   <= a_cmd.rssi;
      out_start  <= a_cmd.sync_take ? start_calc :
                    (a_cmd.status == ST_DONE) ? packet_start_time : '0;
      out_end    <= (a_cmd.status == ST_DONE) ? end_calc : '0;
    end
  end

  assign result.valid         = out_valid;
  assign result.status        = out_status;
  assign result.byte_out      = out_byte;
  assign result.byte_index    = out_index;
  assign result.packet_length = out_length;
  assign result.start_time_us = out_start;
  assign result.end_time_us   = out_end;
  assign result.rssi_out      = out_rssi;

  a_done_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status == ST_DONE) |->
      (out_length >= 8'(PAYLOAD_START)) && (out_length < 8'(MAX_LEN)))
    else $error("completed packet length out of range");

endmodule
`default_nettype wire

// ===== hdl/radio_packet_deframer.sv =====
// Path: an input transfer passes through the command queue, the back end's
// stage A register and its output register. Throughput: one item per cycle
// unless the queue is full; the front end holds the framing state and the
// two-entry command queue lets it run ahead of a stalled result side.
// Reset: synchronous; the framer waits for sync with the length unknown, the
// queue and pipeline are empty and the timing registers are zero.
`default_nettype none
// ----------------------------------------------------------------------------
// Radio packet deframer
// Top level: front end classifier, command queue and time-stamping back end.
// ----------------------------------------------------------------------------
module radio_packet_deframer
  import rpd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  rpd_in_if.sink           item,
  rpd_out_if.source        result
);

  logic push_valid;
  cmd_t push_data;
  logic push_ready;
  logic q_valid;
  cmd_t q_data;
  logic q_pop;

  rpd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  rpd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_data   (q_data),
    .pop        (q_pop)
  );

  rpd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .result    (result)
  );

endmodule
`default_nettype wire
